@@ hdl/rkd_pkg.sv @@
`timescale 1ns / 1ps
package rkd_pkg;

    localparam int TARGETS = 8;
    localparam int SLOT_AW = (TARGETS > 1) ? $clog2(TARGETS) : 1;

    // configuration register indexes
    localparam logic [2:0] CFG_PROCESS_NOISE     = 3'd0;
    localparam logic [2:0] CFG_MEASUREMENT_NOISE = 3'd1;
    localparam logic [2:0] CFG_TX_POWER          = 3'd2;
    localparam logic [2:0] CFG_PATH_LOSS_EXP     = 3'd3;
    localparam logic [2:0] CFG_RSSI_FLOOR        = 3'd4;

    // shared divider widths
    localparam int DIV_NW = 41;
    localparam int DIV_DW = 26;

    localparam logic [19:0] DIST_MAX = 20'hFFFFF;
    localparam logic [23:0] P_MAX    = 24'hFFFFFF;
    localparam logic [23:0] P_INIT   = 24'h010000;
    // 256 * log2(10) in q.16
    localparam logic [25:0] LOG2_TEN_X256 = 26'd55732736;

    typedef struct packed {
        logic [2:0]        slot;
        logic signed [7:0] rssi;
    } t_in;

    typedef struct packed {
        logic [2:0]         slot_out;
        logic signed [15:0] rssi_est;
        logic [19:0]        distance;
        logic               distance_saturated;
    } t_out;

    typedef struct packed {
        logic       start;
        logic [5:0] steps;
    } t_div_ctl;

    // 2^(2^-(b+1)) in q.24
    function automatic logic [24:0] pow2_frac(input logic [3:0] b);
        logic [24:0] v;
        unique case (b)
            4'd0:    v = 25'd23726566;
            4'd1:    v = 25'd19951585;
            4'd2:    v = 25'd18295684;
            4'd3:    v = 25'd17520007;
            4'd4:    v = 25'd17144589;
            4'd5:    v = 25'd16959908;
            4'd6:    v = 25'd16868315;
            4'd7:    v = 25'd16822704;
            4'd8:    v = 25'd16799944;
            4'd9:    v = 25'd16788576;
            4'd10:   v = 25'd16782895;
            4'd11:   v = 25'd16780055;
            4'd12:   v = 25'd16778636;
            4'd13:   v = 25'd16777926;
            4'd14:   v = 25'd16777571;
            default: v = 25'd16777393;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/rkd_div.sv @@
`timescale 1ns / 1ps
// restoring divider, one quotient bit a cycle
module rkd_div import rkd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_ctl          i_ctl,
    input  logic [DIV_NW-1:0] i_num,
    input  logic [DIV_DW-1:0] i_rem0,
    input  logic [DIV_DW-1:0] i_dvs,
    output logic              o_done,
    output logic [DIV_NW-1:0] o_quo,
    output logic [DIV_DW-1:0] o_rem
);

    logic              r_busy;
    logic              r_done;
    logic [5:0]        r_cnt;
    logic [DIV_NW-1:0] r_q;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_dvs;

    logic [DIV_DW:0]   w_trial;
    logic [DIV_DW:0]   w_diff;
    logic              w_ge;
    logic [DIV_DW-1:0] n_rem;

    always_comb begin
        w_trial = {r_rem, r_q[DIV_NW-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        w_ge    = (w_trial >= {1'b0, r_dvs});
        n_rem   = w_ge ? w_diff[DIV_DW-1:0] : w_trial[DIV_DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_q   <= i_num;
            r_rem <= i_rem0;
            r_dvs <= i_dvs;
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_NW-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_rem  = r_rem;

endmodule

@@ hdl/rssi_kalman_distance.sv @@
`timescale 1ns / 1ps
// each report runs through the shared serial divider (17 steps for the gain, 34 for the
// exponent) and 16 steps of the 2^f product loop
// one report at a time; a dropped report frees the input next cycle
// the input is stalled whenever a report is in work; a finished result waits in the
// output register while the next report is taken
// reset (synchronous, active low) restores register defaults and marks every slot unused
module rssi_kalman_distance import rkd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_READ   = 4'd1;
    localparam logic [3:0] S_GSTART = 4'd2;
    localparam logic [3:0] S_GWAIT  = 4'd3;
    localparam logic [3:0] S_MUL    = 4'd4;
    localparam logic [3:0] S_UPD    = 4'd5;
    localparam logic [3:0] S_EXP    = 4'd6;
    localparam logic [3:0] S_DSTART = 4'd7;
    localparam logic [3:0] S_DWAIT  = 4'd8;
    localparam logic [3:0] S_POW    = 4'd9;
    localparam logic [3:0] S_FIN    = 4'd10;

    // configuration
    logic [15:0]       r_pnoise;
    logic [15:0]       r_mnoise;
    logic signed [7:0] r_tx;
    logic [11:0]       r_ple;
    logic signed [7:0] r_floor;

    logic [3:0]         r_state;
    logic [TARGETS-1:0] r_started;

    // per-slot state memory: {estimate, covariance}
    logic [47:0] r_mem [TARGETS];
    logic [47:0] r_rd;

    // datapath registers
    logic [2:0]          r_slot;
    logic signed [7:0]   r_z;
    logic signed [23:0]  r_x;
    logic [24:0]         r_pp;
    logic [25:0]         r_den;
    logic [16:0]         r_k;
    logic signed [43:0]  r_px;
    logic [41:0]         r_pn;
    logic                r_neg;
    logic [33:0]         r_num;
    logic [15:0]         r_dvs;
    logic signed [16:0]  r_ip8;
    logic [15:0]         r_f;
    logic [24:0]         r_m;
    logic [3:0]          r_bi;
    logic signed [15:0]  r_filt;

    t_out r_out;
    logic r_out_valid;

    // divider
    t_div_ctl          w_div_ctl;
    logic [DIV_NW-1:0] w_div_num;
    logic [DIV_DW-1:0] w_div_rem0;
    logic [DIV_DW-1:0] w_div_dvs;
    logic              w_div_done;
    logic [DIV_NW-1:0] w_div_quo;
    logic [DIV_DW-1:0] w_div_rem;

    logic                w_in_acc;
    logic                w_keep;
    logic [SLOT_AW-1:0]  w_in_idx;
    logic [SLOT_AW-1:0]  w_idx;
    logic                w_out_free;

    logic signed [23:0] w_x0;
    logic [23:0]        w_p0;
    logic [24:0]        w_pp;
    logic signed [25:0] w_diff;
    logic signed [23:0] w_xnew;
    logic [23:0]        w_pnew;
    logic signed [7:0]  w_xi;
    logic signed [8:0]  w_e;
    logic [7:0]         w_emag;
    logic [11:0]        w_neff;
    logic [34:0]        w_tq;
    logic [34:0]        w_t;
    logic [49:0]        w_prod;
    logic signed [16:0] w_kk;
    logic [5:0]         w_sh;
    logic [40:0]        w_v;
    logic [19:0]        w_dist;
    logic               w_sat;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_keep     = (int'(i_in_data.slot) < TARGETS) && (i_in_data.rssi >= r_floor);
    assign w_in_idx   = i_in_data.slot[SLOT_AW-1:0];
    assign w_idx      = r_slot[SLOT_AW-1:0];
    assign w_out_free = !r_out_valid || !i_out_stall;

    // configuration writes; unknown indexes fall through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pnoise <= 16'd32;
            r_mnoise <= 16'd2048;
            r_tx     <= -8'sd45;
            r_ple    <= 12'd589;
            r_floor  <= -8'sd90;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PROCESS_NOISE:     r_pnoise <= i_cfg_data;
                CFG_MEASUREMENT_NOISE: r_mnoise <= i_cfg_data;
                CFG_TX_POWER:          r_tx     <= i_cfg_data[7:0];
                CFG_PATH_LOSS_EXP:     r_ple    <= i_cfg_data[11:0];
                CFG_RSSI_FLOOR:        r_floor  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // combinational datapath
    always_comb begin
        // fresh slot starts from tx power and unit covariance
        w_x0 = r_started[w_idx] ? $signed(r_rd[47:24]) : $signed({r_tx, 16'h0000});
        w_p0 = r_started[w_idx] ? r_rd[23:0] : P_INIT;
        w_pp = {1'b0, w_p0} + {1'b0, r_pnoise, 8'h00};

        // innovation in q.16
        w_diff = $signed({{2{r_z[7]}}, r_z, 16'h0000}) - $signed({{2{r_x[23]}}, r_x});

        w_xnew = r_x + r_px[39:16];
        w_pnew = (r_pn[41:16] > {2'b00, P_MAX}) ? P_MAX : r_pn[39:16];

        // truncation of the estimate toward zero
        w_xi   = r_x[23:16] + ((r_x[23] && (r_x[15:0] != 16'h0000)) ? 8'sd1 : 8'sd0);
        w_e    = $signed({r_tx[7], r_tx}) - $signed({w_xi[7], w_xi});
        w_emag = w_e[8] ? 8'(-w_e) : w_e[7:0];
        w_neff = (r_ple == 12'd0) ? 12'd1 : r_ple;

        // floor of the signed quotient
        w_tq = {1'b0, w_div_quo[33:0]};
        if (!r_neg) begin
            w_t = w_tq;
        end else if (w_div_rem != '0) begin
            w_t = ~w_tq;
        end else begin
            w_t = -w_tq;
        end

        w_prod = r_m * pow2_frac(r_bi) + 50'(1 << 23);

        // scale mantissa by 2^(i+8) with round half up
        w_kk   = 17'sd24 - r_ip8;
        w_sh   = w_kk[5:0];
        w_v    = ({16'h0000, r_m} + (41'd1 << (w_sh - 6'd1))) >> w_sh;
        w_sat  = 1'b0;
        w_dist = '0;
        if (r_ip8 >= 17'sd20) begin
            w_sat  = 1'b1;
            w_dist = DIST_MAX;
        end else if (w_kk > 17'sd40) begin
            w_dist = '0;
        end else if (w_v > {21'd0, DIST_MAX}) begin
            w_sat  = 1'b1;
            w_dist = DIST_MAX;
        end else begin
            w_dist = w_v[19:0];
        end
    end

    // divider set-up: gain starts with the remainder already holding pp/2
    always_comb begin
        w_div_ctl.start = 1'b0;
        w_div_ctl.steps = 6'd17;
        w_div_num       = {r_pp[0], 40'd0};
        w_div_rem0      = {2'b00, r_pp[24:1]};
        w_div_dvs       = r_den;
        if (r_state == S_GSTART) begin
            w_div_ctl.start = 1'b1;
        end else if (r_state == S_DSTART) begin
            w_div_ctl.start = 1'b1;
            w_div_ctl.steps = 6'd34;
            w_div_num       = {r_num, 7'd0};
            w_div_rem0      = '0;
            w_div_dvs       = {10'd0, r_dvs};
        end
    end

    rkd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .i_num   (w_div_num),
        .i_rem0  (w_div_rem0),
        .i_dvs   (w_div_dvs),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo),
        .o_rem   (w_div_rem)
    );

    // state memory: read at transfer, written back after the update
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_rd <= r_mem[w_in_idx];
        end
        if (r_state == S_UPD) begin
            r_mem[w_idx] <= {w_xnew, w_pnew};
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_started   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a new result replaces one that leaves in the same cycle
            if (r_state == S_FIN && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc && w_keep) begin
                        r_state <= S_READ;
                    end
                end
                S_READ:   r_state <= S_GSTART;
                S_GSTART: r_state <= S_GWAIT;
                S_GWAIT: begin
                    if (w_div_done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= S_UPD;
                S_UPD: begin
                    r_started[w_idx] <= 1'b1;
                    r_state          <= S_EXP;
                end
                S_EXP:    r_state <= S_DSTART;
                S_DSTART: r_state <= S_DWAIT;
                S_DWAIT: begin
                    if (w_div_done) begin
                        r_state <= S_POW;
                    end
                end
                S_POW: begin
                    if (r_bi == 4'd15) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_slot <= i_in_data.slot;
                r_z    <= i_in_data.rssi;
            end
            S_READ: begin
                r_x   <= w_x0;
                r_pp  <= w_pp;
                r_den <= {1'b0, w_pp} + {2'b00, r_mnoise, 8'h00};
            end
            S_GWAIT: begin
                // zero denominator gives unit gain
                r_k <= (r_den == '0) ? 17'h10000 : w_div_quo[16:0];
            end
            S_MUL: begin
                r_px <= $signed({1'b0, r_k}) * w_diff;
                r_pn <= r_pp * (17'h10000 - r_k);
            end
            S_UPD: r_x <= w_xnew;
            S_EXP: begin
                r_neg  <= w_e[8];
                r_num  <= w_emag * LOG2_TEN_X256;
                r_dvs  <= {1'b0, w_neff, 3'b000} + {3'b000, w_neff, 1'b0};
                r_filt <= r_x[23:8];
            end
            S_DWAIT: begin
                r_ip8 <= $signed({w_t[31], w_t[31:16]}) + 17'sd8;
                r_f   <= w_t[15:0];
                r_m   <= 25'h1000000;
                r_bi  <= 4'd0;
            end
            S_POW: begin
                // fractional bits most significant first
                if (r_f[~r_bi]) begin
                    r_m <= w_prod[48:24];
                end
                r_bi <= r_bi + 4'd1;
            end
            S_FIN: begin
                if (w_out_free) begin
                    r_out.slot_out           <= r_slot;
                    r_out.rssi_est           <= r_filt;
                    r_out.distance           <= w_dist;
                    r_out.distance_saturated <= w_sat;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_keep_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_keep) |=> (r_state == S_READ))
        else $error("kept report did not start the update");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_GWAIT || r_state == S_DWAIT))
        else $error("divider finished outside a wait state");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_FIN))
        else $error("result appeared without finishing an item");

    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.distance_saturated) |-> (o_out_data.distance == DIST_MAX))
        else $error("saturated distance not clipped");

    a_started_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |=> r_started[$past(w_idx)])
        else $error("slot not marked used after write-back");
`endif

endmodule
